@@ rtl/a2e_pkg.sv @@
// Shared constants, types and helper functions for the axis-angle to Euler converter.
package a2e_pkg;

  // Width of the sin/cos CORDIC datapath (Q30 plus headroom).
  localparam int ROT_W = 34;
  // Width of the Q30 intermediate products and the atan2 operands.
  localparam int PW = 40;
  // Width inside the vectoring CORDIC (operand width plus gain headroom).
  localparam int VEC_W = PW + 2;
  // Number of result bits of the square root, one per pipeline step.
  localparam int SQ_STEPS = 31;
  localparam int SQ_W = 62;

  localparam logic signed [ROT_W-1:0] ROT_K = 34'sd652032874;
  localparam logic signed [ROT_W-1:0] ONE_ROT = 34'sd1073741824;
  localparam logic signed [PW-1:0] ONE_PW = 40'sd1073741824;
  localparam logic signed [31:0] ONE_32 = 32'sd1073741824;
  localparam logic [60:0] ONE_SQ = 61'd1 << 60;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [15:0] QUARTER16 = 16'h4000;
  localparam logic [15:0] MINUS_QUARTER16 = 16'hC000;

  localparam logic [14:0] THRESH_RESET = 15'd16351;

  // Pole case codes.
  localparam logic [1:0] POLE_NONE = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TAB [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Operands that wait beside the square root.
  typedef struct packed {
    logic signed [PW-1:0] yaw_num;
    logic signed [PW-1:0] yaw_den;
    logic signed [PW-1:0] roll_num;
    logic signed [PW-1:0] roll_den;
    logic signed [31:0]   sin_pitch;
    logic [1:0]           pole;
  } ops_t;

  // Round to nearest by adding half an LSB, then shift right with floor.
  function automatic logic signed [PW-1:0] round_shift(input logic signed [67:0] v,
                                                       input int unsigned n);
    logic signed [67:0] r;
    r = (v + (68'sd1 <<< (n - 1))) >>> n;
    return r[PW-1:0];
  endfunction

  // 32-bit binary angle to 16 bits, rounded and wrapped.
  function automatic logic [15:0] to16(input logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h0000_8000;
    return r[31:16];
  endfunction

endpackage

@@ rtl/a2e_delay.sv @@
// Shift line with a common advance enable, used to keep side data aligned.
module a2e_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [0:D-1];

  // Shift one place each time the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= din;
      for (int i = 1; i < D; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign dout = line[D-1];

endmodule

@@ rtl/a2e_rot_cordic.sv @@
// Pipelined rotation-mode CORDIC giving sine and cosine of a 32-bit binary angle.
module a2e_rot_cordic #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [31:0]                       angle,
  output logic signed [a2e_pkg::ROT_W-1:0] sin_out,
  output logic signed [a2e_pkg::ROT_W-1:0] cos_out
);
  import a2e_pkg::*;

  logic [31:0] shifted;
  logic        flip_in;
  logic [31:0] folded;

  logic signed [ROT_W-1:0] xr [0:STAGES];
  logic signed [ROT_W-1:0] yr [0:STAGES];
  logic signed [ROT_W-1:0] zr [0:STAGES-1];
  logic [STAGES:0]         fr;

  // Fold the angle into the right half plane; the result is negated later.
  assign shifted = angle + QUARTER_TURN;
  assign flip_in = shifted[31];
  assign folded  = flip_in ? {~angle[31], angle[30:0]} : angle;

  // Entry stage: start vector is the gain-compensated unit on the x axis.
  always_ff @(posedge clk) begin
    if (en) begin
      xr[0] <= ROT_K;
      yr[0] <= '0;
      zr[0] <= $signed({{(ROT_W-32){folded[31]}}, folded});
      fr[0] <= flip_in;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [ROT_W-1:0] xs;
    logic signed [ROT_W-1:0] ys;
    logic signed [ROT_W-1:0] at;
    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;
    assign at = $signed({{(ROT_W-32){1'b0}}, ATAN_TAB[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        fr[i+1] <= fr[i];
        if (!zr[i][ROT_W-1]) begin
          xr[i+1] <= xr[i] - ys;
          yr[i+1] <= yr[i] + xs;
        end else begin
          xr[i+1] <= xr[i] + ys;
          yr[i+1] <= yr[i] - xs;
        end
      end
    end

    if (i < STAGES - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          zr[i+1] <= zr[i][ROT_W-1] ? zr[i] + at : zr[i] - at;
        end
      end
    end
  end

  // Undo the fold by negating both outputs.
  always_ff @(posedge clk) begin
    if (en) begin
      sin_out <= fr[STAGES] ? -yr[STAGES] : yr[STAGES];
      cos_out <= fr[STAGES] ? -xr[STAGES] : xr[STAGES];
    end
  end

endmodule

@@ rtl/a2e_vec_cordic.sv @@
// Pipelined vectoring-mode CORDIC giving atan2(y, x) as a 32-bit binary angle.
module a2e_vec_cordic #(
  parameter int STAGES = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [a2e_pkg::PW-1:0] y_in,
  input  logic signed [a2e_pkg::PW-1:0] x_in,
  output logic [31:0]                    angle
);
  import a2e_pkg::*;

  logic signed [VEC_W-1:0] xe;
  logic signed [VEC_W-1:0] ye;
  logic                    neg;
  logic                    zero;

  logic signed [VEC_W-1:0] xr [0:STAGES-1];
  logic signed [VEC_W-1:0] yr [0:STAGES-1];
  logic [31:0]             acc [0:STAGES];
  logic [STAGES:0]         zf;

  assign xe   = {{(VEC_W-PW){x_in[PW-1]}}, x_in};
  assign ye   = {{(VEC_W-PW){y_in[PW-1]}}, y_in};
  assign neg  = x_in[PW-1];
  assign zero = (x_in == '0) && (y_in == '0);

  // Entry stage: a left half-plane vector is turned by half a turn.
  always_ff @(posedge clk) begin
    if (en) begin
      xr[0]  <= neg ? -xe : xe;
      yr[0]  <= neg ? -ye : ye;
      acc[0] <= neg ? HALF_TURN : '0;
      zf[0]  <= zero;
    end
  end

  // One micro-rotation per stage, driving y toward zero.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic up;
    assign up = (yr[i] > 0);

    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1]  <= zf[i];
        acc[i+1] <= up ? acc[i] + ATAN_TAB[i] : acc[i] - ATAN_TAB[i];
      end
    end

    if (i < STAGES - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          if (up) begin
            xr[i+1] <= xr[i] + (yr[i] >>> i);
            yr[i+1] <= yr[i] - (xr[i] >>> i);
          end else begin
            xr[i+1] <= xr[i] - (yr[i] >>> i);
            yr[i+1] <= yr[i] + (xr[i] >>> i);
          end
        end
      end
    end
  end

  // A zero vector gives angle zero.
  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zf[STAGES] ? '0 : acc[STAGES];
    end
  end

endmodule

@@ rtl/a2e_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module a2e_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] arg,
  output logic [30:0] root
);
  import a2e_pkg::*;

  logic [SQ_W-1:0] rem [0:SQ_STEPS-1];
  logic [SQ_W-1:0] rt  [0:SQ_STEPS];

  // Entry stage.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {1'b0, arg};
      rt[0]  <= '0;
    end
  end

  // Restoring square root, trial bit moving down two places per stage.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = 62'd1 << (60 - 2 * k);
    logic [SQ_W-1:0] trial;
    logic            take;
    assign trial = rt[k] + BIT;
    assign take  = (rem[k] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rt[k+1] <= take ? (rt[k] >> 1) + BIT : (rt[k] >> 1);
      end
    end

    if (k < SQ_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= take ? rem[k] - trial : rem[k];
        end
      end
    end
  end

  assign root = rt[SQ_STEPS][30:0];

endmodule

@@ rtl/axis_angle_to_euler.sv @@
// Axis-angle to Euler angle converter: top level with the product and pole stages.
//
// Converts a unit axis (Q2.14) and a rotation angle (binary angle) into pitch, yaw and
// roll binary angles, reporting the gimbal-lock pole case on m_tuser. The block is
// fully pipelined: it takes one word every cycle unless the output stalls. Each word
// passes in series through the sin/cos CORDIC chain, the product and pole stages, the
// 31-step square root used for the arcsine, and the atan2 CORDIC chain.
// When m_tvalid is high and m_tready low the whole pipeline holds and s_tready drops
// in the same cycle.
// The pole threshold may only be written while no word is in flight.
module axis_angle_to_euler #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,      // axis_x, axis_y, axis_z, rotation_angle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,      // pitch_angle, yaw_angle, roll_angle
  output logic [1:0]  m_tuser,      // pole_case
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data
);
  import a2e_pkg::*;

  localparam int LAT_ROT   = CORDIC_STAGES + 2;
  localparam int LAT_SQ    = SQ_STEPS + 1;
  localparam int LAT_VEC   = CORDIC_STAGES + 2;
  localparam int LAT_TOTAL = LAT_ROT + LAT_SQ + LAT_VEC + 6;

  logic                    en;
  logic [LAT_TOTAL-1:0]    vld;
  logic [14:0]             thresh;

  logic [31:0]             full_ang;
  logic [31:0]             half_ang;
  logic signed [ROT_W-1:0] sin_f;
  logic signed [ROT_W-1:0] cos_f;
  logic signed [ROT_W-1:0] sin_h;
  logic signed [ROT_W-1:0] cos_h;
  logic [47:0]             axes_d;
  logic signed [15:0]      xd;
  logic signed [15:0]      yd;
  logic signed [15:0]      zd;

  logic signed [31:0]      p_xy, p_xz, p_yz, p_xx, p_yy, p_zz;

  logic signed [ROT_W-1:0] m1_t;
  logic signed [31:0]      m1_xy, m1_xz, m1_yz;
  logic signed [32:0]      m1_yyzz, m1_xxzz;
  logic signed [49:0]      m1_zs, m1_ys, m1_xs, m1_xsh;
  logic signed [ROT_W-1:0] m1_ch;

  logic signed [65:0]      q_xyt, q_xzt, q_yzt;
  logic signed [66:0]      q_yyzzt, q_xxzzt;

  logic signed [PW-1:0]    m2_xyt, m2_xzt, m2_yzt, m2_yyzzt, m2_xxzzt;
  logic signed [PW-1:0]    m2_zs, m2_ys, m2_xs, m2_xsh;
  logic signed [ROT_W-1:0] m2_ch;

  logic signed [PW-1:0]    m3_p, m3_yn, m3_yd, m3_rn, m3_rd, m3_xsh;
  logic signed [ROT_W-1:0] m3_ch;

  logic signed [PW-1:0]    thr;
  logic                    north;
  logic                    south;
  ops_t                    m4_ops;
  ops_t                    ops_d;

  logic signed [63:0]      vsq;
  logic [60:0]             m5_vv;
  logic [60:0]             sq_arg;
  logic [30:0]             root;

  logic [31:0]             acc_yaw;
  logic [31:0]             acc_pitch;
  logic [31:0]             acc_roll;
  logic [1:0]              pole_d;
  logic [31:0]             yaw2;

  logic [15:0]             out_pitch;
  logic [15:0]             out_yaw;
  logic [15:0]             out_roll;
  logic [1:0]              out_pole;

  // The pipeline advances unless a finished word is held at the output.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT_TOTAL-1];

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT_TOTAL-2:0], s_tvalid};
    end
  end

  // Pole threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh <= cfg_wr_data;
    end
  end

  // Sine and cosine of the full angle and of the half angle.
  assign full_ang = {s_tdata[63:48], 16'h0000};
  assign half_ang = {s_tdata[63], s_tdata[63:48], 15'h0000};

  a2e_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_full (
    .clk(clk), .en(en), .angle(full_ang), .sin_out(sin_f), .cos_out(cos_f)
  );

  a2e_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_half (
    .clk(clk), .en(en), .angle(half_ang), .sin_out(sin_h), .cos_out(cos_h)
  );

  a2e_delay #(.W(48), .D(LAT_ROT)) u_axes_dly (
    .clk(clk), .en(en), .din(s_tdata[47:0]), .dout(axes_d)
  );

  assign xd = axes_d[15:0];
  assign yd = axes_d[31:16];
  assign zd = axes_d[47:32];

  assign p_xy = xd * yd;
  assign p_xz = xd * zd;
  assign p_yz = yd * zd;
  assign p_xx = xd * xd;
  assign p_yy = yd * yd;
  assign p_zz = zd * zd;

  // First product stage: axis products, t = 1 - c and the products with sine.
  always_ff @(posedge clk) begin
    if (en) begin
      m1_t    <= ONE_ROT - cos_f;
      m1_xy   <= p_xy;
      m1_xz   <= p_xz;
      m1_yz   <= p_yz;
      m1_yyzz <= {p_yy[31], p_yy} + {p_zz[31], p_zz};
      m1_xxzz <= {p_xx[31], p_xx} + {p_zz[31], p_zz};
      m1_zs   <= zd * sin_f;
      m1_ys   <= yd * sin_f;
      m1_xs   <= xd * sin_f;
      m1_xsh  <= xd * sin_h;
      m1_ch   <= cos_h;
    end
  end

  assign q_xyt   = m1_xy * m1_t;
  assign q_xzt   = m1_xz * m1_t;
  assign q_yzt   = m1_yz * m1_t;
  assign q_yyzzt = m1_yyzz * m1_t;
  assign q_xxzzt = m1_xxzz * m1_t;

  // Second product stage: products with t; all products rounded back to Q30.
  always_ff @(posedge clk) begin
    if (en) begin
      m2_xyt   <= round_shift(q_xyt, 28);
      m2_xzt   <= round_shift(q_xzt, 28);
      m2_yzt   <= round_shift(q_yzt, 28);
      m2_yyzzt <= round_shift(q_yyzzt, 28);
      m2_xxzzt <= round_shift(q_xxzzt, 28);
      m2_zs    <= round_shift(m1_zs, 14);
      m2_ys    <= round_shift(m1_ys, 14);
      m2_xs    <= round_shift(m1_xs, 14);
      m2_xsh   <= round_shift(m1_xsh, 14);
      m2_ch    <= m1_ch;
    end
  end

  // Sum stage: pole test value and the atan2 operands for yaw and roll.
  always_ff @(posedge clk) begin
    if (en) begin
      m3_p   <= m2_xyt + m2_zs;
      m3_yn  <= m2_ys - m2_xzt;
      m3_yd  <= ONE_PW - m2_yyzzt;
      m3_rn  <= m2_xs - m2_yzt;
      m3_rd  <= ONE_PW - m2_xxzzt;
      m3_xsh <= m2_xsh;
      m3_ch  <= m2_ch;
    end
  end

  // Pole decision; the north test wins over the south test.
  assign thr   = $signed({9'b0, thresh, 16'h0000});
  assign north = (m3_p > thr);
  assign south = (m3_p < -thr);

  // Pole stage: pick the yaw operands and clamp the arcsine argument.
  always_ff @(posedge clk) begin
    if (en) begin
      if (north) begin
        m4_ops.pole <= POLE_NORTH;
      end else if (south) begin
        m4_ops.pole <= POLE_SOUTH;
      end else begin
        m4_ops.pole <= POLE_NONE;
      end
      if (north || south) begin
        m4_ops.yaw_num <= m3_xsh;
        m4_ops.yaw_den <= {{(PW-ROT_W){m3_ch[ROT_W-1]}}, m3_ch};
      end else begin
        m4_ops.yaw_num <= m3_yn;
        m4_ops.yaw_den <= m3_yd;
      end
      m4_ops.roll_num <= m3_rn;
      m4_ops.roll_den <= m3_rd;
      if (m3_p > ONE_PW) begin
        m4_ops.sin_pitch <= ONE_32;
      end else if (m3_p < -ONE_PW) begin
        m4_ops.sin_pitch <= -ONE_32;
      end else begin
        m4_ops.sin_pitch <= m3_p[31:0];
      end
    end
  end

  // Square of the arcsine argument, then cos(pitch) = sqrt(1 - v*v).
  assign vsq = m4_ops.sin_pitch * m4_ops.sin_pitch;

  always_ff @(posedge clk) begin
    if (en) begin
      m5_vv <= vsq[60:0];
    end
  end

  assign sq_arg = ONE_SQ - m5_vv;

  a2e_isqrt u_isqrt (
    .clk(clk), .en(en), .arg(sq_arg), .root(root)
  );

  a2e_delay #(.W($bits(ops_t)), .D(LAT_SQ + 1)) u_ops_dly (
    .clk(clk), .en(en), .din(m4_ops), .dout(ops_d)
  );

  // Three atan2 units in parallel.
  a2e_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec_yaw (
    .clk(clk), .en(en), .y_in(ops_d.yaw_num), .x_in(ops_d.yaw_den), .angle(acc_yaw)
  );

  a2e_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec_pitch (
    .clk(clk), .en(en),
    .y_in({{(PW-32){ops_d.sin_pitch[31]}}, ops_d.sin_pitch}),
    .x_in({{(PW-31){1'b0}}, root}),
    .angle(acc_pitch)
  );

  a2e_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec_roll (
    .clk(clk), .en(en), .y_in(ops_d.roll_num), .x_in(ops_d.roll_den), .angle(acc_roll)
  );

  a2e_delay #(.W(2), .D(LAT_VEC)) u_pole_dly (
    .clk(clk), .en(en), .din(ops_d.pole), .dout(pole_d)
  );

  assign yaw2 = {acc_yaw[30:0], 1'b0};

  // Output register: final rounding to 16 bits and the fixed pole angles.
  always_ff @(posedge clk) begin
    if (en) begin
      out_pole <= pole_d;
      case (pole_d)
        POLE_NORTH: begin
          out_pitch <= QUARTER16;
          out_yaw   <= to16(yaw2);
          out_roll  <= '0;
        end
        POLE_SOUTH: begin
          out_pitch <= MINUS_QUARTER16;
          out_yaw   <= to16(32'd0 - yaw2);
          out_roll  <= '0;
        end
        default: begin
          out_pitch <= to16(acc_pitch);
          out_yaw   <= to16(acc_yaw);
          out_roll  <= to16(acc_roll);
        end
      endcase
    end
  end

  assign m_tdata = {out_roll, out_yaw, out_pitch};
  assign m_tuser = out_pole;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the axis-angle to Euler angle converter.
module testbench;
  import a2e_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = 2 * STAGES + 42;
  localparam int N_RANDOM = 1600;
  localparam int MAX_CYCLES = 400000;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam longint ATAN_STEP [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] roll;
    logic [1:0]  pole;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = '0;

  logic [63:0] pending_words[$];
  euler_t expected_angles[$];
  logic [14:0] threshold;
  int mismatches = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit hold_input = 1'b0;
  bit s_tready_seen = 1'b0;

  axis_angle_to_euler #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Floor shift of a signed value.
  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rshr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Rotation-mode CORDIC on a 32-bit binary angle.
  function automatic void cordic_sincos(logic [31:0] a, output longint sn, output longint cs);
    logic [31:0] q;
    bit flip;
    longint x, y, zr, nx;
    q = a + QUARTER_TURN;
    flip = q[31];
    if (flip) a = a + HALF_TURN;
    zr = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (zr >= 0) begin
        nx = x - fshr(y, i);
        y = y + fshr(x, i);
        zr -= ATAN_STEP[i];
      end else begin
        nx = x + fshr(y, i);
        y = y - fshr(x, i);
        zr += ATAN_STEP[i];
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  // Vectoring-mode CORDIC returning a 32-bit binary angle.
  function automatic logic [31:0] cordic_atan2(longint y, longint x);
    logic [31:0] acc;
    longint nx;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = HALF_TURN;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (y > 0) begin
        nx = x + fshr(y, i);
        y = y - fshr(x, i);
        acc += ATAN_STEP[i][31:0];
      end else begin
        nx = x - fshr(y, i);
        y = y + fshr(x, i);
        acc -= ATAN_STEP[i][31:0];
      end
      x = nx;
    end
    return acc;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [15:0] angle16(logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h8000;
    return r[31:16];
  endfunction

  // Euler angles for one axis-angle word under the current threshold.
  function automatic euler_t convert_axis_angle(logic [63:0] w, logic [14:0] thr_reg);
    euler_t e;
    longint x, y, z, th, s, c, t, p, thr, sh, ch, ny, dy, v, root;
    logic [31:0] a;
    x = longint'($signed(w[15:0]));
    y = longint'($signed(w[31:16]));
    z = longint'($signed(w[47:32]));
    th = longint'($signed(w[63:48]));
    cordic_sincos({w[63:48], 16'h0}, s, c);
    t = (64'sd1 <<< 30) - c;
    p = rshr(x * y * t, 28) + rshr(z * s, 14);
    thr = longint'(thr_reg) * 65536;
    if (p > thr || p < -thr) begin
      a = 32'(th * 32768);
      cordic_sincos(a, sh, ch);
      a = cordic_atan2(rshr(x * sh, 14), ch);
      e.roll = '0;
      if (p > thr) begin
        e.pitch = QUARTER16;
        e.yaw = angle16(2 * a);
        e.pole = POLE_NORTH;
      end else begin
        e.pitch = MINUS_QUARTER16;
        e.yaw = angle16(-(2 * a));
        e.pole = POLE_SOUTH;
      end
      return e;
    end
    ny = rshr(y * s, 14) - rshr(x * z * t, 28);
    dy = (64'sd1 <<< 30) - rshr((y * y + z * z) * t, 28);
    e.yaw = angle16(cordic_atan2(ny, dy));
    v = p > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : (p < -(64'sd1 <<< 30) ? -(64'sd1 <<< 30) : p);
    root = int_sqrt((64'd1 << 60) - longint'(v * v));
    e.pitch = angle16(cordic_atan2(v, root));
    ny = rshr(x * s, 14) - rshr(y * z * t, 28);
    dy = (64'sd1 <<< 30) - rshr((x * x + z * z) * t, 28);
    e.roll = angle16(cordic_atan2(ny, dy));
    e.pole = POLE_NONE;
    return e;
  endfunction

  function automatic logic [15:0] axis_component();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'(16384);
      2: return -16'(16384);
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Mostly unit axes about one principal direction, so poles get hit often.
  function automatic logic [63:0] random_word();
    logic [15:0] c[3];
    int k;
    if ($urandom_range(0, 2) == 0) begin
      c[0] = axis_component(); c[1] = axis_component(); c[2] = axis_component();
    end else begin
      k = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) c[i] = 16'($signed($urandom_range(0, 400)) - 200);
      c[k] = $urandom_range(0, 1) ? 16'(16384 - $urandom_range(0, 40))
                                 : -16'(16384 - $urandom_range(0, 40));
    end
    return {16'($urandom), c[2], c[1], c[0]};
  endfunction

  // Sender: one word per handshake, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready_seen) begin
      if (pending_words.size() > 0 && !hold_input && (calm || $urandom_range(0, 99) >= 25)) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_words.pop_front();
      end else begin
        s_tvalid <= 1'b0;
        s_tdata <= 64'($urandom) << 32 | 64'($urandom);
      end
    end
  end

  // Remember at the rising edge whether the word on the bus was taken.
  always @(posedge clk) begin
    s_tready_seen <= s_tvalid && s_tready;
    if (s_tvalid && s_tready && !rst)
      expected_angles.push_back(convert_axis_angle(s_tdata, threshold));
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_tready <= calm || $urandom_range(0, 99) >= 25;
  end

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk) begin
    euler_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h/%h", m_tdata, m_tuser);
      end else begin
        e = expected_angles.pop_front();
        if (m_tdata[15:0] !== e.pitch || m_tdata[31:16] !== e.yaw
            || m_tdata[47:32] !== e.roll || m_tuser !== e.pole) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pitch %h/%h yaw %h/%h roll %h/%h pole %0d/%0d (exp/act)",
                     e.pitch, m_tdata[15:0], e.yaw, m_tdata[31:16], e.roll,
                     m_tdata[47:32], e.pole, m_tuser);
        end
      end
    end
    if (cycle_count >= MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_angles.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_threshold(logic [14:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    threshold = value;
  endtask

  initial begin
    logic [14:0] settings[5];
    logic [15:0] ext[6];
    threshold = THRESH_RESET;
    settings = '{15'd16351, 15'd0, 15'd16384, 15'd32767, 15'd12000};
    ext = '{16'h8000, 16'h7FFF, 16'(16384), -16'(16384), 16'h0000, 16'hFFFF};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, exact poles both ways, zero axis.
    for (int i = 0; i < 6; i++) pending_words.push_back({ext[i], ext[i], ext[(i+1)%6], ext[i]});
    pending_words.push_back({16'h4000, 16'(16384), 16'h0000, 16'h0000});
    pending_words.push_back({16'hC000, 16'(16384), 16'h0000, 16'h0000});
    pending_words.push_back({16'h8000, 16'(16384), 16'h0000, 16'h0000});
    pending_words.push_back({16'h4000, 16'h0000, 16'(16384), 16'(16384)});
    pending_words.push_back({16'h4000, 16'h0000, -16'(16384), 16'(16384)});
    pending_words.push_back(64'h0);
    pending_words.push_back({16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
    drain();

    // Random phases under several thresholds.
    foreach (settings[k]) begin
      set_threshold(settings[k]);
      calm = (k == 2);
      for (int n = 0; n < N_RANDOM / 5; n++) pending_words.push_back(random_word());
      if (k == 3) begin
        // Hold the sender until the pipeline is empty.
        while (pending_words.size() > N_RANDOM / 10) @(posedge clk);
        hold_input = 1'b1;
        while (s_tvalid || expected_angles.size() > 0) @(posedge clk);
        hold_input = 1'b0;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/a2e_pkg.sv
rtl/a2e_delay.sv
rtl/a2e_rot_cordic.sv
rtl/a2e_vec_cordic.sv
rtl/a2e_isqrt.sv
rtl/axis_angle_to_euler.sv
tb/testbench.sv
